>>> src/tct_pkg.sv
// Shared types and constants for the timestamp clock tracker.
package tct_pkg;

   localparam int ARR_W   = 52;
   localparam int TIC_W   = 48;
   localparam int TIME_W  = 54;
   localparam int SLOPE_W = 63;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int DIV_STEPS = 64;
   localparam int MUL_STEPS = TIC_W;
   localparam int STEP_W    = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_STRIDE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HAS_PRESET    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESET_SLOPE  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_GAP_LIMIT     = 3'd4;

   localparam logic [9:0]  STRIDE_RESET = 10'd128;
   localparam logic [39:0] GAP_RESET    = 40'd10000000;

   localparam logic signed [52:0] JUMP_US      = 53'sd60000000;
   localparam logic signed [48:0] MAX_TIC_STEP = 49'sd1000000000;
   localparam logic signed [63:0] SUM_LIM      = 64'sd4611686018427387904;
   localparam logic [63:0]        SLOPE_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef enum logic {
      TCT_OP_DIV,
      TCT_OP_MUL
   } tct_op_type;

   typedef struct packed {
      logic       start;
      tct_op_type op;
      logic [63:0] hi;
      logic [63:0] lo;
      logic [63:0] dvs;
   } tct_unit_req_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_SETUP,
      S_RDP,
      S_RDJ,
      S_EVAL,
      S_SUMS,
      S_RATIO_GO,
      S_RATIO_WT,
      S_SDIV_GO,
      S_SDIV_WT,
      S_RDIV_GO,
      S_RDIV_WT,
      S_MT_GO,
      S_MT_WT,
      S_MA_GO,
      S_MA_WT,
      S_MUL_GO,
      S_MUL_WT,
      S_FIN
   } tct_state_type;

endpackage

>>> src/tct_seq_unit.sv
// Shared iterative unit: restoring divide or shift-add multiply, one bit a cycle.
module tct_seq_unit import tct_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  tct_unit_req_type req,
   output logic             busy,
   output logic             done,
   output logic [64:0]      res_hi,
   output logic [63:0]      res_lo
);

   logic [64:0]       rem_ff, rem_in;
   logic [63:0]       w_ff, w_in;
   logic [63:0]       d_ff;
   tct_op_type        op_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic              busy_ff, done_ff;
   logic [64:0]       trial, diff, msum;
   logic              ge;

   always_comb begin
      trial = {rem_ff[63:0], w_ff[63]};
      ge    = trial >= {1'b0, d_ff};
      diff  = trial - {1'b0, d_ff};
      msum  = rem_ff + (w_ff[0] ? {1'b0, d_ff} : 65'd0);
      rem_in = rem_ff;
      w_in   = w_ff;
      case (op_ff)
         TCT_OP_DIV: begin
            rem_in = ge ? diff : trial;
            w_in   = {w_ff[62:0], ge};
         end
         default: begin
            rem_in = {1'b0, msum[64:1]};
            w_in   = {msum[0], w_ff[63:1]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == STEP_W'(1));
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= (req.op == TCT_OP_DIV) ? STEP_W'(DIV_STEPS) : STEP_W'(MUL_STEPS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - STEP_W'(1);
            if (cnt_ff == STEP_W'(1)) busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         rem_ff <= {1'b0, req.hi};
         w_ff   <= req.lo;
         d_ff   <= req.dvs;
         op_ff  <= req.op;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         w_ff   <= w_in;
      end
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign res_hi = rem_ff;
   assign res_lo = w_ff;

endmodule

>>> src/timestamp_clock_tracker.sv
// Timestamp clock tracker top level: sequencer, tracking state, ring memories and ports.
//
// Each req transaction pairs a noisy arrival time with a reference tic count and
// returns one rsp transaction holding the smoothed time (mean arrival plus slope
// times tic distance from the mean tic, plus offset_us) and the current slope.
// Work is done one transaction at a time by a small sequencer around a single
// shared unit that divides or multiplies one bit per cycle. A tracker reset op or
// the first sample after a restart goes from setup straight to the result. A steady
// sample runs the control states, one divide for the measured ratio (none while a
// preset slope holds before the window is full), two more for the slope decay once
// the window is full, two on every second sample for the means, and a multiply for
// the prediction. req_ready is high only while the sequencer is idle; a
// finished result sits in the rsp register, and the next transaction is taken
// while it waits. The ring memories need no clearing pass after reset. Configuration
// writes are taken at any time but are meant for idle periods only.
module timestamp_clock_tracker import tct_pkg::*; #(
   parameter int RING_DEPTH = 1024
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_op,
   input  logic [ARR_W-1:0]             req_arrival_us,
   input  logic [TIC_W-1:0]             req_ref_tic,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [TIME_W-1:0]     rsp_time_us,
   output logic [SLOPE_W-1:0]           rsp_slope_q40,
   output logic                         rsp_discontinuity,
   output logic                         rsp_internal_reference,
   output logic                         rsp_forced_zero,
   output logic                         rsp_went_backwards,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [CSR_IDX_W-1:0]         csr_index,
   input  logic [CSR_DATA_W-1:0]        csr_data
);

   localparam int IDX_W = $clog2(RING_DEPTH);
   localparam logic [31:0] DEPTH32 = 32'(RING_DEPTH);

   // configuration
   logic [9:0]         stride_ff;
   logic signed [31:0] offset_ff;
   logic               has_preset_ff;
   logic [62:0]        preset_ff;
   logic [39:0]        gap_ff;

   // tracking state
   logic [IDX_W-1:0]        widx_ff;
   logic [31:0]             cnt_ff;
   logic [ARR_W-1:0]        mean_a_ff;
   logic [TIC_W-1:0]        mean_t_ff;
   logic signed [63:0]      sum_a_ff, sum_t_ff;
   logic [63:0]             slope_ff;
   logic [TIC_W-1:0]        itic_ff;
   logic                    use_int_ff;
   logic signed [TIME_W-1:0] latest_ff;

   // per-transaction work registers
   tct_state_type           state_ff, state_in;
   logic                    op_ff;
   logic [ARR_W-1:0]        x_ff, ap_ff, aj_ff;
   logic [TIC_W-1:0]        u_ff, tk_ff, tp_ff, tj_ff;
   logic [IDX_W-1:0]        k_ff, p_ff, j_ff;
   logic                    jeq_ff, recent_ff, disc_ff, fz_ff, full_ff, even_ff;
   logic signed [52:0]      dxv_ff;
   logic signed [48:0]      duv_ff;
   logic [63:0]             r_ff, sq_ff;
   logic signed [TIME_W-1:0] y_ff;

   // result register
   logic                    rsp_valid_ff;
   logic signed [TIME_W-1:0] rsp_time_ff;
   logic [SLOPE_W-1:0]      rsp_slope_ff;
   logic                    rsp_disc_ff, rsp_int_ff, rsp_fz_ff, rsp_back_ff;

   // ring memories
   logic [ARR_W-1:0] arr_mem [RING_DEPTH];
   logic [TIC_W-1:0] tic_mem [RING_DEPTH];
   logic [ARR_W-1:0] rd_a_ff;
   logic [TIC_W-1:0] rd_t_ff;
   logic [IDX_W-1:0] rd_addr;
   logic             ring_we;

   tct_unit_req_type unit_req;
   logic             unit_busy, unit_done;
   logic [64:0]      unit_hi;
   logic [63:0]      unit_lo;

   tct_seq_unit u_unit (
      .clock  (clock),
      .reset  (reset),
      .req    (unit_req),
      .busy   (unit_busy),
      .done   (unit_done),
      .res_hi (unit_hi),
      .res_lo (unit_lo)
   );

   function automatic logic signed [TIME_W-1:0] sat_time(input logic signed [63:0] v);
      logic signed [63:0] hi_lim, lo_lim;
      hi_lim = 64'sd9007199254740991;
      lo_lim = -64'sd9007199254740992;
      if (v > hi_lim) sat_time = hi_lim[TIME_W-1:0];
      else if (v < lo_lim) sat_time = lo_lim[TIME_W-1:0];
      else sat_time = v[TIME_W-1:0];
   endfunction

   function automatic logic signed [63:0] sat_sum(input logic signed [63:0] v);
      if (v > SUM_LIM) sat_sum = SUM_LIM;
      else if (v < -SUM_LIM) sat_sum = -SUM_LIM;
      else sat_sum = v;
   endfunction

   // effective stride: zero acts as one, capped below the ring depth
   logic [31:0] n_eff;
   always_comb begin
      n_eff = (stride_ff == 10'd0) ? 32'd1 : 32'(stride_ff);
      if (n_eff >= DEPTH32) n_eff = DEPTH32 - 32'd1;
   end

   // setup-time decisions
   logic signed [55:0] gdiff;
   logic               restart;
   logic [31:0]        cnt0, cnt_new;
   logic [IDX_W-1:0]   k_new;
   logic               full_new;
   logic [31:0]        j32;
   always_comb begin
      gdiff   = $signed({4'b0, x_ff}) - 56'(latest_ff);
      restart = gdiff > $signed({16'b0, gap_ff});
      cnt0    = restart ? 32'd0 : cnt_ff;
      k_new   = restart ? '0 : widx_ff;
      cnt_new = cnt0 + 32'd1;
      full_new = cnt_new > n_eff;
      if (32'(k_new) >= n_eff) j32 = 32'(k_new) - n_eff;
      else j32 = 32'(k_new) + DEPTH32 - n_eff;
   end

   // evaluation-time decisions; rd_*_ff holds the entry at j
   logic signed [52:0] xd;
   logic               disc_n, recent_n, bad;
   logic [ARR_W-1:0]   aj_e;
   logic signed [48:0] duv0, duv1;
   logic [TIC_W-1:0]   tk1;
   always_comb begin
      xd       = $signed({1'b0, x_ff}) - $signed({1'b0, ap_ff});
      disc_n   = (xd > JUMP_US) || (u_ff < tp_ff);
      recent_n = recent_ff && !(disc_n && (xd > $signed({13'b0, gap_ff})));
      aj_e     = jeq_ff ? x_ff : rd_a_ff;
      duv0     = jeq_ff ? 49'sd0 : ($signed({1'b0, tk_ff}) - $signed({1'b0, rd_t_ff}));
      bad      = recent_n && ((duv0 <= 49'sd0) || (duv0 > MAX_TIC_STEP));
      tk1      = bad ? itic_ff : tk_ff;
      duv1     = jeq_ff ? 49'sd0 : ($signed({1'b0, tk1}) - $signed({1'b0, rd_t_ff}));
   end

   // ratio operands
   logic [52:0] ax;
   logic [48:0] ad;
   logic        ratio_zero, ratio_sat;
   always_comb begin
      ax = dxv_ff[52] ? 53'(-dxv_ff) : 53'(dxv_ff);
      ad = duv_ff[48] ? 49'(-duv_ff) : 49'(duv_ff);
      ratio_zero = (dxv_ff == 53'sd0) || (dxv_ff[52] != duv_ff[48]);
      ratio_sat  = {20'b0, ax[52:24]} >= ad;
   end

   // prediction operand and product
   logic signed [48:0] dpred;
   logic [TIC_W-1:0]   adpred;
   logic [112:0]       prod;
   logic [60:0]        term;
   logic signed [63:0] y64;
   always_comb begin
      dpred  = $signed({1'b0, u_ff}) - $signed({1'b0, mean_t_ff});
      adpred = dpred[48] ? TIC_W'(-dpred) : TIC_W'(dpred);
      prod   = {unit_hi, unit_lo[63:64-MUL_STEPS]};
      term   = (prod[112:40] > (73'd1 << 60)) ? (61'd1 << 60) : prod[100:40];
      y64    = dpred[48] ? ($signed({12'b0, mean_a_ff}) - $signed({3'b0, term}))
                         : ($signed({12'b0, mean_a_ff}) + $signed({3'b0, term}));
   end

   // sums for the window
   logic signed [48:0] dt_e;
   logic signed [52:0] da_e;
   logic [TIC_W-1:0]   tjx;
   always_comb begin
      tjx  = jeq_ff ? tk_ff : tj_ff;
      dt_e = full_ff ? ($signed({1'b0, u_ff}) - $signed({1'b0, tjx})) : $signed({1'b0, u_ff});
      da_e = full_ff ? ($signed({1'b0, x_ff}) - $signed({1'b0, aj_ff}))
                     : $signed({1'b0, x_ff});
   end

   logic          out_free;
   tct_state_type after_slope;
   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign after_slope = even_ff ? S_MT_GO : (fz_ff ? S_FIN : S_MUL_GO);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:     if (req_valid) state_in = S_SETUP;
         S_SETUP:    state_in = (op_ff || cnt_new <= 32'd1) ? S_FIN : S_RDP;
         S_RDP:      state_in = S_RDJ;
         S_RDJ:      state_in = S_EVAL;
         S_EVAL:     state_in = S_SUMS;
         S_SUMS: begin
            if (!fz_ff && (full_ff || !has_preset_ff)) state_in = S_RATIO_GO;
            else state_in = after_slope;
         end
         S_RATIO_GO: state_in = S_RATIO_WT;
         S_RATIO_WT: if (unit_done) state_in = full_ff ? S_SDIV_GO : after_slope;
         S_SDIV_GO:  state_in = S_SDIV_WT;
         S_SDIV_WT:  if (unit_done) state_in = S_RDIV_GO;
         S_RDIV_GO:  state_in = S_RDIV_WT;
         S_RDIV_WT:  if (unit_done) state_in = after_slope;
         S_MT_GO:    state_in = S_MT_WT;
         S_MT_WT:    if (unit_done) state_in = S_MA_GO;
         S_MA_GO:    state_in = S_MA_WT;
         S_MA_WT:    if (unit_done) state_in = fz_ff ? S_FIN : S_MUL_GO;
         S_MUL_GO:   state_in = S_MUL_WT;
         S_MUL_WT:   if (unit_done) state_in = S_FIN;
         S_FIN:      if (out_free) state_in = S_IDLE;
         default:    state_in = S_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      unit_req = '0;
      req_ready = (state_ff == S_IDLE);
      rd_addr   = p_ff;
      ring_we   = (state_ff == S_FIN) && out_free && !op_ff;
      unique case (state_ff)
         S_RDJ: rd_addr = j_ff;
         S_RATIO_GO: begin
            unit_req.start = 1'b1;
            unit_req.op    = TCT_OP_DIV;
            unit_req.hi    = {35'b0, ax[52:24]};
            unit_req.lo    = {ax[23:0], 40'b0};
            unit_req.dvs   = {15'b0, ad};
         end
         S_SDIV_GO: begin
            unit_req.start = 1'b1;
            unit_req.op    = TCT_OP_DIV;
            unit_req.lo    = slope_ff;
            unit_req.dvs   = 64'(n_eff);
         end
         S_RDIV_GO: begin
            unit_req.start = 1'b1;
            unit_req.op    = TCT_OP_DIV;
            unit_req.lo    = r_ff;
            unit_req.dvs   = 64'(n_eff);
         end
         S_MT_GO: begin
            unit_req.start = 1'b1;
            unit_req.op    = TCT_OP_DIV;
            unit_req.lo    = (sum_t_ff > 64'sd0) ? sum_t_ff : 64'd0;
            unit_req.dvs   = full_ff ? 64'(n_eff) : 64'(cnt_ff);
         end
         S_MA_GO: begin
            unit_req.start = 1'b1;
            unit_req.op    = TCT_OP_DIV;
            unit_req.lo    = (sum_a_ff > 64'sd0) ? sum_a_ff : 64'd0;
            unit_req.dvs   = full_ff ? 64'(n_eff) : 64'(cnt_ff);
         end
         S_MUL_GO: begin
            unit_req.start = 1'b1;
            unit_req.op    = TCT_OP_MUL;
            unit_req.lo    = 64'(adpred);
            unit_req.dvs   = slope_ff;
         end
         default: ;
      endcase
   end

   // ring memories: one write port, one registered read port each
   always_ff @(posedge clock) begin
      if (ring_we) begin
         arr_mem[k_ff] <= x_ff;
         tic_mem[k_ff] <= tk_ff;
      end
      rd_a_ff <= arr_mem[rd_addr];
      rd_t_ff <= tic_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // configuration, tracking state and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         stride_ff     <= STRIDE_RESET;
         offset_ff     <= '0;
         has_preset_ff <= 1'b0;
         preset_ff     <= '0;
         gap_ff        <= GAP_RESET;
         widx_ff       <= '0;
         cnt_ff        <= '0;
         mean_a_ff     <= '0;
         mean_t_ff     <= '0;
         sum_a_ff      <= '0;
         sum_t_ff      <= '0;
         slope_ff      <= '0;
         itic_ff       <= '0;
         use_int_ff    <= 1'b0;
         latest_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_WINDOW_STRIDE: stride_ff <= csr_data[9:0];
               CSR_OFFSET:        offset_ff <= $signed(csr_data[31:0]);
               CSR_HAS_PRESET:    has_preset_ff <= csr_data[0];
               CSR_PRESET_SLOPE: begin
                  preset_ff <= csr_data[62:0];
                  slope_ff  <= {1'b0, csr_data[62:0]};
               end
               CSR_GAP_LIMIT:     gap_ff <= csr_data[39:0];
               default: ;
            endcase
         end
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;

         case (state_ff)
            S_SETUP: begin
               if (op_ff) begin
                  widx_ff   <= '0;
                  cnt_ff    <= '0;
                  itic_ff   <= '0;
                  latest_ff <= '0;
               end else begin
                  if (cnt0 == 32'd0) begin
                     mean_a_ff <= x_ff;
                     mean_t_ff <= u_ff;
                     sum_a_ff  <= $signed({12'b0, x_ff});
                     sum_t_ff  <= $signed({16'b0, u_ff});
                  end
                  if (use_int_ff) itic_ff <= itic_ff + TIC_W'(1);
                  widx_ff <= (32'(k_new) == DEPTH32 - 32'd1) ? '0 : k_new + IDX_W'(1);
                  cnt_ff  <= cnt_new;
               end
            end
            S_EVAL: begin
               if (bad) begin
                  use_int_ff <= 1'b1;
                  itic_ff    <= itic_ff + TIC_W'(1);
               end
            end
            S_SUMS: begin
               sum_t_ff <= sat_sum(sum_t_ff + 64'(dt_e));
               sum_a_ff <= sat_sum(sum_a_ff + 64'(da_e));
            end
            S_RATIO_WT: begin
               if (unit_done && !full_ff) begin
                  if (ratio_zero) slope_ff <= '0;
                  else if (ratio_sat || unit_lo[63]) slope_ff <= SLOPE_MAX;
                  else slope_ff <= unit_lo;
               end
            end
            S_RDIV_WT: if (unit_done) slope_ff <= slope_ff - sq_ff + unit_lo;
            S_MT_WT: begin
               if (unit_done) mean_t_ff <= (|unit_lo[63:TIC_W]) ? '1 : unit_lo[TIC_W-1:0];
            end
            S_MA_WT: begin
               if (unit_done) mean_a_ff <= (|unit_lo[63:ARR_W]) ? '1 : unit_lo[ARR_W-1:0];
            end
            S_FIN: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  if (!op_ff) latest_ff <= y_ff;
               end
            end
            default: ;
         endcase
      end
   end

   // per-transaction payload registers
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            op_ff <= req_op;
            x_ff  <= req_arrival_us;
            u_ff  <= req_ref_tic;
         end
         S_SETUP: begin
            k_ff      <= k_new;
            p_ff      <= (k_new == '0) ? IDX_W'(RING_DEPTH - 1) : k_new - IDX_W'(1);
            j_ff      <= full_new ? j32[IDX_W-1:0] : '0;
            jeq_ff    <= (full_new ? j32[IDX_W-1:0] : '0) == k_new;
            full_ff   <= full_new;
            even_ff   <= ~cnt_new[0];
            recent_ff <= (cnt0 != 32'd0);
            tk_ff     <= use_int_ff ? itic_ff : u_ff;
            disc_ff   <= 1'b0;
            fz_ff     <= 1'b0;
            y_ff      <= $signed({2'b0, x_ff});
         end
         S_RDJ: begin
            ap_ff <= rd_a_ff;
            tp_ff <= rd_t_ff;
         end
         S_EVAL: begin
            disc_ff   <= disc_n;
            recent_ff <= recent_n;
            tk_ff     <= tk1;
            aj_ff     <= aj_e;
            tj_ff     <= rd_t_ff;
            dxv_ff    <= $signed({1'b0, x_ff}) - $signed({1'b0, aj_e});
            duv_ff    <= duv1;
            if ((duv1 == 49'sd0) && (full_ff || !has_preset_ff)) begin
               fz_ff <= 1'b1;
               y_ff  <= '0;
            end
         end
         S_RATIO_WT: begin
            if (unit_done) begin
               if (ratio_zero) r_ff <= '0;
               else if (ratio_sat || unit_lo[63]) r_ff <= SLOPE_MAX;
               else r_ff <= unit_lo;
            end
         end
         S_SDIV_WT: if (unit_done) sq_ff <= unit_lo;
         S_MUL_WT:  if (unit_done) y_ff <= sat_time(y64);
         S_FIN: begin
            if (out_free) begin
               rsp_slope_ff <= slope_ff[SLOPE_W-1:0];
               rsp_int_ff   <= use_int_ff;
               if (op_ff) begin
                  rsp_time_ff <= '0;
                  rsp_disc_ff <= 1'b0;
                  rsp_fz_ff   <= 1'b0;
                  rsp_back_ff <= 1'b0;
               end else begin
                  rsp_time_ff <= fz_ff ? '0 : sat_time(64'(y_ff) + 64'(offset_ff));
                  rsp_disc_ff <= disc_ff;
                  rsp_fz_ff   <= fz_ff;
                  rsp_back_ff <= (y_ff < latest_ff) && !recent_ff;
               end
            end
         end
         default: ;
      endcase
   end

   assign csr_ready              = 1'b1;
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_time_us            = rsp_time_ff;
   assign rsp_slope_q40          = rsp_slope_ff;
   assign rsp_discontinuity      = rsp_disc_ff;
   assign rsp_internal_reference = rsp_int_ff;
   assign rsp_forced_zero        = rsp_fz_ff;
   assign rsp_went_backwards     = rsp_back_ff;

   // the shared unit is never mid-operation while a new transaction can enter
   a_idle_unit: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !unit_busy) else $error("unit busy while idle");

   // the internal tic counter, once chosen, stays in use
   a_int_sticky: assert property (@(posedge clock) disable iff (reset)
      use_int_ff |=> use_int_ff) else $error("internal reference dropped");

   // a forced-zero result carries zero time
   a_fz_time: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_forced_zero) |-> (rsp_time_us == '0))
      else $error("forced zero with nonzero time");

   // unit results are only consumed in a wait state
   a_done_wait: assert property (@(posedge clock) disable iff (reset)
      unit_done |-> (state_ff == S_RATIO_WT || state_ff == S_SDIV_WT ||
                     state_ff == S_RDIV_WT || state_ff == S_MT_WT ||
                     state_ff == S_MA_WT || state_ff == S_MUL_WT))
      else $error("unit done outside wait state");

endmodule

>>> bench/tb_timestamp_clock_tracker.sv
// Self-checking testbench for the timestamp clock tracker.
module tb_timestamp_clock_tracker;
   import tct_pkg::*;

   localparam int DEPTH = 1024;
   localparam longint ARR_MAX   = 64'h000F_FFFF_FFFF_FFFF;
   localparam longint TIC_MAX   = 64'h0000_FFFF_FFFF_FFFF;
   localparam longint TIME_MAX  = 64'sd9007199254740991;
   localparam longint TIME_MIN  = -64'sd9007199254740992;
   localparam longint JUMP_LIM  = 60000000;
   localparam longint STEP_LIM  = 1000000000;
   localparam longint SUM_BOUND = 64'sd4611686018427387904;
   localparam bit [63:0] SLOPE_TOP = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam bit OP_SAMPLE = 1'b0;
   localparam bit OP_CLEAR  = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_op = OP_SAMPLE;
   logic [ARR_W-1:0] req_arrival_us = '0;
   logic [TIC_W-1:0] req_ref_tic = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [TIME_W-1:0] rsp_time_us;
   logic [SLOPE_W-1:0] rsp_slope_q40;
   logic rsp_discontinuity, rsp_internal_reference, rsp_forced_zero, rsp_went_backwards;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   timestamp_clock_tracker DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one smoothed-time transaction as the tracker should return it
   typedef struct {
      logic signed [TIME_W-1:0] time_us;
      logic [SLOPE_W-1:0]       slope;
      bit                       disc, intref, fzero, back;
      bit                       pinned;     // time also checked against a typed value
      longint                   pinned_time;
   } track_result_t;

   track_result_t track_q[$];
   int errors = 0;

   // tracker copy: registers
   longint    cfg_stride, cfg_offset, cfg_gap;
   bit        cfg_preset_on;
   bit [63:0] cfg_preset;
   // tracker copy: state
   longint      hist_arr[DEPTH];
   longint      hist_tic[DEPTH];
   int          wr_ptr;
   int unsigned n_seen;
   longint      avg_arr, avg_tic, sum_arr, sum_tic, last_y;
   bit [63:0]   slope_st;
   bit [47:0]   int_tic;
   bit          int_mode;

   // sender and receiver idle odds, percent
   int send_idle = 0, recv_idle = 0;
   // typed expectation riding along with the transaction in flight
   bit     cur_pinned = 0;
   longint cur_pinned_time = 0;

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint mean_clip(longint s, longint n, longint mx);
      longint m;
      m = s / n;
      if (m < 0) return 0;
      return m > mx ? mx : m;
   endfunction

   // dx/du in Q23.40, negative ratios read as 0, saturating at 2^63-1
   function automatic bit [63:0] tic_ratio(longint dx, longint du);
      bit [63:0]  ax, ad;
      bit [127:0] q;
      if (dx == 0 || ((dx < 0) != (du < 0))) return 0;
      ax = dx < 0 ? -dx : dx;
      ad = du < 0 ? -du : du;
      q = ({64'b0, ax} << 40) / {64'b0, ad};
      return q > {64'b0, SLOPE_TOP} ? SLOPE_TOP : q[63:0];
   endfunction

   function automatic longint smoothed_at(longint u);
      longint     d;
      bit [63:0]  ad;
      bit [127:0] prod, term;
      d = u - avg_tic;
      ad = d < 0 ? -d : d;
      prod = {64'b0, slope_st} * {64'b0, ad};
      term = prod >> 40;
      if (term > (128'd1 << 60)) term = 128'd1 << 60;
      return clip(d < 0 ? avg_arr - longint'(term[63:0]) : avg_arr + longint'(term[63:0]),
                  TIME_MIN, TIME_MAX);
   endfunction

   function automatic longint take_int_tic();
      longint v;
      v = longint'(int_tic);
      int_tic = int_tic + 1;
      return v;
   endfunction

   function automatic void tracker_clear();
      cfg_stride = STRIDE_RESET; cfg_offset = 0; cfg_preset_on = 0;
      cfg_preset = 0; cfg_gap = GAP_RESET;
      wr_ptr = 0; n_seen = 0; avg_arr = 0; avg_tic = 0; sum_arr = 0; sum_tic = 0;
      slope_st = 0; int_tic = 0; int_mode = 0; last_y = 0;
   endfunction

   // advance the tracker copy by one transaction and return its result
   function automatic track_result_t track_step(bit op, longint x, longint u);
      track_result_t r;
      longint n, y, xd, dxv, duv;
      int k, j, p;
      bit recent, disc, fz;
      recent = 1; disc = 0; fz = 0;
      r = '{default: 0};
      if (op == OP_CLEAR) begin
         wr_ptr = 0; n_seen = 0; int_tic = 0; last_y = 0;
         r.slope = slope_st[62:0];
         r.intref = int_mode;
         return r;
      end
      n = cfg_stride == 0 ? 1 : cfg_stride;
      if (n >= DEPTH) n = DEPTH - 1;
      if (x - last_y > cfg_gap) begin
         n_seen = 0; wr_ptr = 0;
      end
      if (n_seen == 0) begin
         recent = 0;
         avg_arr = x; avg_tic = u; sum_arr = x; sum_tic = u;
      end
      k = wr_ptr;
      hist_arr[k] = x;
      hist_tic[k] = int_mode ? take_int_tic() : u;
      wr_ptr = (k + 1) % DEPTH;
      n_seen++;
      y = x;
      if (n_seen > 1) begin
         p = (k + DEPTH - 1) % DEPTH;
         xd = x - hist_arr[p];
         if (xd > JUMP_LIM || u - hist_tic[p] < 0) begin
            disc = 1;
            if (xd > cfg_gap) recent = 0;
         end
         j = longint'(n_seen) > n ? int'((k + DEPTH - n) % DEPTH) : 0;
         dxv = hist_arr[k] - hist_arr[j];
         duv = hist_tic[k] - hist_tic[j];
         // implausible tic step while warm: switch to the internal counter for good
         if (recent && (duv <= 0 || duv > STEP_LIM)) begin
            int_mode = 1;
            hist_tic[k] = take_int_tic();
            duv = hist_tic[k] - hist_tic[j];
         end
         if (longint'(n_seen) > n) begin
            sum_tic = clip(sum_tic + u - hist_tic[j], -SUM_BOUND, SUM_BOUND);
            sum_arr = clip(sum_arr + x - hist_arr[j], -SUM_BOUND, SUM_BOUND);
            if (!n_seen[0]) begin
               avg_tic = mean_clip(sum_tic, n, TIC_MAX);
               avg_arr = mean_clip(sum_arr, n, ARR_MAX);
            end
            if (duv == 0) fz = 1;
            else slope_st = slope_st - slope_st / 64'(n) + tic_ratio(dxv, duv) / 64'(n);
         end else begin
            sum_tic = clip(sum_tic + u, -SUM_BOUND, SUM_BOUND);
            sum_arr = clip(sum_arr + x, -SUM_BOUND, SUM_BOUND);
            if (!n_seen[0]) begin
               avg_tic = mean_clip(sum_tic, longint'(n_seen), TIC_MAX);
               avg_arr = mean_clip(sum_arr, longint'(n_seen), ARR_MAX);
            end
            if (!cfg_preset_on) begin
               if (duv == 0) fz = 1;
               else slope_st = tic_ratio(dxv, duv);
            end
         end
         y = fz ? 0 : smoothed_at(u);
      end
      r.back = (y < last_y) && !recent;
      last_y = y;
      r.time_us = fz ? 0 : clip(y + cfg_offset, TIME_MIN, TIME_MAX);
      r.slope = slope_st[62:0];
      r.disc = disc;
      r.intref = int_mode;
      r.fzero = fz;
      return r;
   endfunction

   task automatic report_mismatch(string what);
      errors++;
      $display("%0t mismatch: %s", $realtime, what);
   endtask

   // monitor: check results first, then record newly accepted transactions
   always @(posedge clock) begin
      track_result_t e;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (track_q.size() == 0) report_mismatch("result with no transaction pending");
            else begin
               e = track_q.pop_front();
               if (rsp_time_us !== e.time_us)
                  report_mismatch($sformatf("time_us %0d, want %0d", rsp_time_us, e.time_us));
               if (e.pinned && rsp_time_us !== TIME_W'(e.pinned_time))
                  report_mismatch($sformatf("time_us %0d, table %0d", rsp_time_us,
                                            e.pinned_time));
               if (rsp_slope_q40 !== e.slope)
                  report_mismatch($sformatf("slope %h, want %h", rsp_slope_q40, e.slope));
               if (rsp_discontinuity !== e.disc)
                  report_mismatch($sformatf("discontinuity %b", rsp_discontinuity));
               if (rsp_internal_reference !== e.intref)
                  report_mismatch($sformatf("internal_reference %b", rsp_internal_reference));
               if (rsp_forced_zero !== e.fzero)
                  report_mismatch($sformatf("forced_zero %b", rsp_forced_zero));
               if (rsp_went_backwards !== e.back)
                  report_mismatch($sformatf("went_backwards %b", rsp_went_backwards));
            end
         end
         if (req_valid && req_ready) begin
            e = track_step(req_op, longint'(req_arrival_us), longint'(req_ref_tic));
            e.pinned = cur_pinned;
            e.pinned_time = cur_pinned_time;
            track_q.push_back(e);
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_STRIDE: cfg_stride = longint'(csr_data[9:0]);
               CSR_OFFSET:        cfg_offset = longint'($signed(csr_data[31:0]));
               CSR_HAS_PRESET:    cfg_preset_on = csr_data[0];
               CSR_PRESET_SLOPE: begin
                  cfg_preset = {1'b0, csr_data[62:0]};
                  slope_st = cfg_preset;   // writing the preset also loads the slope
               end
               CSR_GAP_LIMIT:     cfg_gap = longint'(csr_data[39:0]);
               default: ;
            endcase
         end
      end
   end

   // receiver stalls at random
   always @(negedge clock)
      rsp_ready <= ($urandom_range(99) >= recv_idle);

   // one req transaction; entered and left at a falling edge
   task automatic send_tstamp(bit op, longint x, longint u, bit pin = 0, longint pin_t = 0);
      while ($urandom_range(99) < send_idle) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_op = op;
      req_arrival_us = x[ARR_W-1:0];
      req_ref_tic = u[TIC_W-1:0];
      cur_pinned = pin;
      cur_pinned_time = pin_t;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // drain outstanding transactions, then let the sequencer settle
   task automatic wait_drained();
      req_valid = 1'b0;
      while (track_q.size() != 0) @(negedge clock);
      repeat (450) @(negedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic set_tracking(longint stride, longint offs, bit preset_on, bit [63:0] preset,
                               longint gap);
      wait_drained();
      csr_write(CSR_WINDOW_STRIDE, stride);
      csr_write(CSR_OFFSET, offs);
      csr_write(CSR_HAS_PRESET, preset_on);
      csr_write(CSR_PRESET_SLOPE, preset);
      csr_write(CSR_GAP_LIMIT, gap);
   endtask

   // Random traffic: mostly steady tracks (restart, then a run of well-behaved pairs),
   // with tracker clears mixed in; 'broken' adds junk pairs and tic steps backwards.
   task automatic run_tracks(int items, bit broken);
      int sent, len, sx, su;
      longint x, u;
      sent = 0;
      x = 0;
      while (sent < items) begin
         if ($urandom_range(99) < 3) begin
            send_tstamp(OP_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
            sent++;
         end else if (broken && $urandom_range(99) < 20) begin
            send_tstamp(OP_SAMPLE, {$urandom, $urandom} & ARR_MAX, {$urandom, $urandom} & TIC_MAX);
            sent++;
         end else begin
            len = ($urandom_range(99) < 5) ? $urandom_range(40, 300) : $urandom_range(1, 40);
            if ($urandom_range(1)) x = longint'({$urandom, $urandom} & ARR_MAX) % (ARR_MAX - 64'd1 << 32);
            else x = x + cfg_gap + $urandom_range(1, 100000);
            if (x > ARR_MAX - (64'd1 << 32) || x < 0) x = $urandom_range(0, 1000000);
            u = longint'({$urandom, $urandom} & TIC_MAX) % (TIC_MAX - (64'd1 << 28));
            sx = $urandom_range(500, 3000);
            su = $urandom_range(1, 2000);
            for (int i = 0; i < len && sent < items; i++) begin
               send_tstamp(OP_SAMPLE, x, u);
               sent++;
               x = x + sx + $urandom_range(0, 400) - 200;
               if ($urandom_range(99) < 2) x = x + 61000000;   // long silence
               u = u + su;
               if (broken && $urandom_range(99) < 5) u = u - 3 * su;
            end
         end
      end
   endtask

   typedef struct {
      bit     op;
      longint x, u;
      bit     pin;
      longint pin_t;
   } tstamp_row_t;

   // directed rows under reset settings; typed times only where obvious
   tstamp_row_t rows[] = '{
      '{OP_CLEAR,  0,        0,       1, 0},         // clear right after reset
      '{OP_SAMPLE, 1000,     100,     1, 1000},      // first sample returns arrival
      '{OP_SAMPLE, 2000,     1100,    0, 0},
      '{OP_SAMPLE, 3010,     2100,    0, 0},
      '{OP_SAMPLE, 3990,     3100,    0, 0},
      '{OP_SAMPLE, 5020,     4100,    0, 0},
      '{OP_SAMPLE, ARR_MAX,  TIC_MAX, 1, ARR_MAX},   // huge gap: restart at the top
      '{OP_CLEAR,  ARR_MAX,  TIC_MAX, 1, 0},         // clear ignores its fields
      '{OP_SAMPLE, 0,        0,       1, 0},         // first after clear, all zero
      '{OP_SAMPLE, 5000,     500,     0, 0},
      '{OP_SAMPLE, 9000,     1000,    0, 0},
      '{OP_SAMPLE, 70009000, 2000,    1, 70009000},  // 70 s gap restarts tracking
      '{OP_SAMPLE, 70010000, 3000,    0, 0},
      '{OP_SAMPLE, 70011100, 4000,    0, 0}
   };

   initial begin
      tracker_clear();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (rows[i])
         send_tstamp(rows[i].op, rows[i].x, rows[i].u, rows[i].pin, rows[i].pin_t);

      send_idle = 37; recv_idle = 66;
      set_tracking(8, 0, 0, 0, 10000000);
      run_tracks(300, 0);

      send_idle = 66; recv_idle = 37;
      set_tracking(1023, -64'sd2147483648, 1, SLOPE_TOP, 10000000);
      run_tracks(250, 0);

      send_idle = 0; recv_idle = 0;
      set_tracking(1, 2147483647, 0, 0, 40'hFF_FFFF_FFFF);   // 60 s jumps flag, no restart
      run_tracks(300, 0);

      set_tracking(0, 1234, 1, 64'd1 << 40, 0);              // every later sample restarts
      run_tracks(150, 0);

      // last: junk and backward tic steps latch the internal counter for good
      set_tracking(16, -500, 0, 64'd1 << 40, 10000000);
      run_tracks(250, 1);

      wait_drained();
      if (errors == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end

   initial begin
      #60000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> timestamp_clock_tracker.f
src/tct_pkg.sv
src/tct_seq_unit.sv
src/timestamp_clock_tracker.sv
bench/tb_timestamp_clock_tracker.sv
